[rtl/gta_pkg.sv]
// Shared constants and types for the greedy track association block.
package gta_pkg;

    localparam int MAX_POINTS = 8;
    localparam int MAX_TRACKS = 16;
    localparam int COORD_BITS = 12;

    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int TR_W   = $clog2(MAX_TRACKS);
    localparam int PCNT_W = PT_W + 1;
    localparam int TCNT_W = TR_W + 1;
    localparam int DIST_W = 2 * COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;

    // Broadcast from the sequencer to every track cell
    typedef struct packed {
        coord_t             x;
        coord_t             y;
        logic [PT_W-1:0]    pidx;
        logic               pvld;
        logic               clr_best;
        logic               clr_taken;
        logic [TCNT_W-1:0]  old_cnt;
        logic               wr_en;
        logic [TR_W-1:0]    wr_trk;
        logic               take_en;
        logic [TR_W-1:0]    take_trk;
    } cmd_t;

    // Candidate pair passed along the cell chain
    typedef struct packed {
        logic               found;
        logic [DIST_W-1:0]  d;
        logic [TR_W-1:0]    t;
        logic [PT_W-1:0]    p;
    } link_t;

endpackage

[rtl/gta_cell.sv]
// One track cell: tail position, local best pair and one chain stage.
module gta_cell
    import gta_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [TR_W-1:0] cell_idx,
    input  cmd_t            cmd,
    input  link_t           link_in,
    output link_t           link_out
);

    coord_t              tail_x_reg;
    coord_t              tail_y_reg;
    logic                taken_reg;
    logic                dist_vld_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [PT_W-1:0]     dist_p_reg;
    link_t               best_reg;
    link_t               link_reg;

    logic                active;
    coord_t              dx;
    coord_t              dy;
    logic [2*COORD_BITS-1:0] sqx;
    logic [2*COORD_BITS-1:0] sqy;
    logic [DIST_W-1:0]   dist_next;
    link_t               own;
    logic                best_upd;
    logic                take_own;

    // distance of the broadcast point to this tail
    always_comb
    begin
        active    = (TCNT_W'(cell_idx) < cmd.old_cnt) && !taken_reg;
        dx        = (tail_x_reg > cmd.x) ? tail_x_reg - cmd.x : cmd.x - tail_x_reg;
        dy        = (tail_y_reg > cmd.y) ? tail_y_reg - cmd.y : cmd.y - tail_y_reg;
        sqx       = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
        sqy       = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
        dist_next = DIST_W'(sqx) + DIST_W'(sqy);
        own       = best_reg;
        own.t     = cell_idx;
        best_upd  = dist_vld_reg && (!best_reg.found || dist_reg < best_reg.d);
        // ties keep the incoming pair: it comes from a lower track
        take_own  = own.found && (!link_in.found || own.d < link_in.d);
    end

    // tail, local best and chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_x_reg   <= '0;
            tail_y_reg   <= '0;
            taken_reg    <= 1'b0;
            dist_vld_reg <= 1'b0;
            dist_reg     <= '0;
            dist_p_reg   <= '0;
            best_reg     <= '0;
            link_reg     <= '0;
        end
        else
        begin
            if (cmd.wr_en && cmd.wr_trk == cell_idx)
            begin
                tail_x_reg <= cmd.x;
                tail_y_reg <= cmd.y;
            end
            if (cmd.clr_taken)
                taken_reg <= 1'b0;
            else if (cmd.take_en && cmd.take_trk == cell_idx)
                taken_reg <= 1'b1;
            dist_vld_reg <= cmd.pvld && active;
            dist_reg     <= dist_next;
            dist_p_reg   <= cmd.pidx;
            if (cmd.clr_best)
                best_reg.found <= 1'b0;
            else if (best_upd)
            begin
                best_reg.found <= 1'b1;
                best_reg.d     <= dist_reg;
                best_reg.t     <= cell_idx;
                best_reg.p     <= dist_p_reg;
            end
            link_reg <= take_own ? own : link_in;
        end
    end

    assign link_out = link_reg;

endmodule

[rtl/greedy_track_association_top.sv]
// Greedy nearest-neighbor track association: sequencer, point buffer and track cell chain.
// Points are taken one beat per cycle while idle; the frame_end beat starts matching.
// Matching runs min(points, old tracks) + 1 rounds, each a point scan and a pass along
// the cell chain; then the points are walked once to open tracks, then one result beat
// per point. Input stalls until the last result.
// Reset clears all counts and taken flags; tails, buffered points and result flags need no clearing.
module greedy_track_association_top
    import gta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  coord_t            pos_x,
    input  coord_t            pos_y,
    input  logic              frame_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PT_W-1:0]   point_index,
    output logic [TR_W-1:0]   track_index,
    output logic              opened_track,
    output logic              dropped,
    output logic              last_result
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_CHAIN, S_DECIDE, S_OPEN, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [PCNT_W-1:0]      fcnt_reg;
    logic [PCNT_W-1:0]      n_reg;
    logic [TCNT_W-1:0]      trk_cnt_reg;
    logic [TCNT_W-1:0]      old_cnt_reg;
    logic [MAX_POINTS-1:0]  ptaken_reg;
    logic [PCNT_W-1:0]      p_reg;
    logic [TCNT_W-1:0]      c_reg;

    coord_t                 frame_x_arr [MAX_POINTS];
    coord_t                 frame_y_arr [MAX_POINTS];
    logic [TR_W-1:0]        asg_arr     [MAX_POINTS];
    logic [MAX_POINTS-1:0]  opened_reg;
    logic [MAX_POINTS-1:0]  drop_reg;

    link_t                  chain [MAX_TRACKS+1];
    link_t                  win;
    cmd_t                   cmd;
    logic                   in_fire;
    logic                   out_fire;
    logic                   start;
    logic [PT_W-1:0]        rd_idx;
    logic                   trk_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_fire  = out_valid && !out_stall;
    assign start     = in_fire && frame_end;
    assign win       = chain[MAX_TRACKS];
    assign rd_idx    = (state_reg == S_DECIDE) ? win.p : p_reg[PT_W-1:0];
    assign trk_free  = (trk_cnt_reg < TCNT_W'(MAX_TRACKS));
    assign chain[0]  = '0;

    // broadcast to the cells
    always_comb
    begin
        cmd.x         = frame_x_arr[rd_idx];
        cmd.y         = frame_y_arr[rd_idx];
        cmd.pidx      = rd_idx;
        cmd.pvld      = (state_reg == S_SCAN) && !ptaken_reg[rd_idx];
        cmd.clr_best  = (state_reg == S_DECIDE) || start;
        cmd.clr_taken = start;
        cmd.old_cnt   = old_cnt_reg;
        cmd.take_en   = (state_reg == S_DECIDE) && win.found;
        cmd.take_trk  = win.t;
        cmd.wr_en     = cmd.take_en
                     || ((state_reg == S_OPEN) && !ptaken_reg[rd_idx] && trk_free);
        cmd.wr_trk    = (state_reg == S_DECIDE) ? win.t : trk_cnt_reg[TR_W-1:0];
    end

    // track cell chain
    for (genvar i = 0; i < MAX_TRACKS; i++)
    begin : g_cell
        gta_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (TR_W'(i)),
            .cmd      (cmd),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fcnt_reg    <= '0;
            n_reg       <= '0;
            trk_cnt_reg <= '0;
            old_cnt_reg <= '0;
            ptaken_reg  <= '0;
            p_reg       <= '0;
            c_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (fcnt_reg < PCNT_W'(MAX_POINTS))
                            fcnt_reg <= fcnt_reg + 1'b1;
                        if (frame_end)
                        begin
                            n_reg       <= (fcnt_reg < PCNT_W'(MAX_POINTS)) ?
                                           fcnt_reg + 1'b1 : fcnt_reg;
                            ptaken_reg  <= '0;
                            old_cnt_reg <= trk_cnt_reg;
                            p_reg       <= '0;
                            state_reg   <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (p_reg == n_reg - 1'b1)
                        state_reg <= S_DRAIN;
                    else
                        p_reg <= p_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    c_reg     <= '0;
                    state_reg <= S_CHAIN;
                end
                S_CHAIN:
                begin
                    if (c_reg == TCNT_W'(MAX_TRACKS - 1))
                        state_reg <= S_DECIDE;
                    else
                        c_reg <= c_reg + 1'b1;
                end
                S_DECIDE:
                begin
                    p_reg <= '0;
                    if (win.found)
                    begin
                        ptaken_reg[win.p] <= 1'b1;
                        state_reg         <= S_SCAN;
                    end
                    else
                        state_reg <= S_OPEN;
                end
                S_OPEN:
                begin
                    if (!ptaken_reg[rd_idx] && trk_free)
                        trk_cnt_reg <= trk_cnt_reg + 1'b1;
                    if (p_reg == n_reg - 1'b1)
                    begin
                        p_reg     <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        p_reg <= p_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        if (p_reg == n_reg - 1'b1)
                        begin
                            fcnt_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                            p_reg <= p_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // point buffer and per-point results
    always_ff @(posedge clk)
    begin
        if (in_fire && fcnt_reg < PCNT_W'(MAX_POINTS))
        begin
            frame_x_arr[fcnt_reg[PT_W-1:0]] <= pos_x;
            frame_y_arr[fcnt_reg[PT_W-1:0]] <= pos_y;
        end
        if (state_reg == S_DECIDE && win.found)
            asg_arr[win.p] <= win.t;
        if (state_reg == S_OPEN)
        begin
            if (ptaken_reg[rd_idx])
            begin
                opened_reg[rd_idx] <= 1'b0;
                drop_reg[rd_idx]   <= 1'b0;
            end
            else if (trk_free)
            begin
                asg_arr[rd_idx]    <= trk_cnt_reg[TR_W-1:0];
                opened_reg[rd_idx] <= 1'b1;
                drop_reg[rd_idx]   <= 1'b0;
            end
            else
            begin
                asg_arr[rd_idx]    <= '0;
                opened_reg[rd_idx] <= 1'b0;
                drop_reg[rd_idx]   <= 1'b1;
            end
        end
    end

    // result beat
    assign point_index  = p_reg[PT_W-1:0];
    assign track_index  = asg_arr[p_reg[PT_W-1:0]];
    assign opened_track = opened_reg[p_reg[PT_W-1:0]];
    assign dropped      = drop_reg[p_reg[PT_W-1:0]];
    assign last_result  = (p_reg == n_reg - 1'b1);

    a_trk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        trk_cnt_reg <= TCNT_W'(MAX_TRACKS))
        else $error("track count past capacity");
    a_start_stall: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> in_stall)
        else $error("input not stalled after frame end");
    a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (p_reg < n_reg))
        else $error("result index past frame size");
    a_win_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && win.found) |-> !ptaken_reg[win.p])
        else $error("winning point already matched");

endmodule
